// ----- rtl/hwsl_pkg.sv -----
// Package for the hazard-weighted survival lookup: widths, constants, types.
// No dependencies.
`timescale 1ns / 1ps
package hwsl_pkg;
    localparam int TIME_W  = 32;
    localparam int RATIO_W = 24;
    localparam int LOG_W   = 32;
    localparam int SUM_W   = 48;
    localparam int SURV_W  = 17;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int ENTRY_W = TIME_W + RATIO_W + LOG_W + SUM_W;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [23:0] LN2_Q24 = 24'd11629080;
    localparam logic [SURV_W-1:0] SURV_ONE = 17'd65536;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;     // capture input item
        logic clr_tbl;     // restart: clear newest-entry state
        logic app_wsum;    // compute appended weighted sum
        logic app_wr;      // write entry, bump count
        logic srch_init;   // lo=0, hi=count-1
        logic srch_rd;     // issue read at mid
        logic srch_upd;    // update lo/hi from read data
        logic fin_rd;      // issue read at lo
        logic fin_mul;     // partial term product
        logic fin_add;     // total sum
        logic exp_init;    // start exponential
        logic exp_step;    // one Taylor step: load the divider
        logic exp_div;     // one divider chunk of eight quotient bits
        logic exp_done;    // final rounding into result
        logic res_trivial; // result = 1.0
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic srch_done;
        logic t_zero;
        logic exp_last;
        logic exp_skip;
        logic div_last;
    } t_sts;
endpackage

// ----- rtl/hwsl_if.sv -----
// Valid/ready channel interfaces for input and result items.
// Depends on hwsl_pkg.
`timescale 1ns / 1ps
interface hwsl_in_if import hwsl_pkg::*; ();
    logic valid;
    logic ready;
    logic action;
    logic restart;
    logic [TIME_W-1:0] time_point;
    logic [RATIO_W-1:0] hazard_ratio;
    logic signed [LOG_W-1:0] log_survival;
    modport source (output valid, action, restart, time_point, hazard_ratio, log_survival,
                    input ready);
    modport sink (input valid, action, restart, time_point, hazard_ratio, log_survival,
                  output ready);
endinterface

interface hwsl_out_if import hwsl_pkg::*; ();
    logic valid;
    logic ready;
    logic [SURV_W-1:0] survival;
    logic table_empty;
    logic sum_saturated;
    modport source (output valid, survival, table_empty, sum_saturated, input ready);
    modport sink (input valid, survival, table_empty, sum_saturated, output ready);
endinterface

// ----- rtl/hazard_weighted_survival_lookup.sv -----
// Top level of the hazard-weighted survival lookup.
// Channels: input items on in_ch (append or query), results on out_ch.
// An append writes the table and gives no result. A query with time zero or
// an empty table answers 1.0 without a search. Other queries run a binary search
// over the table memory, each step a read address, a registered read and an
// update, about log2(entries) steps, then the last search check and the
// partial term, then a ten-step series exponential (a load, then a divide by
// the step number in chunks of eight quotient bits), skipped when the sum is
// non-negative or too far below zero. The single-port table memory and the
// serial series with its divider set how long a query takes.
// One item is worked on at a time.
// The result stays on out_ch until it is taken; a stalled receiver holds
// the block, and no new item is accepted until then.
// Reset clears the entry count and the newest-entry state; table contents
// are not cleared and never read beyond the count.
// Depends on hwsl_pkg, hwsl_if, hwsl_ctrl, hwsl_dp.
`timescale 1ns / 1ps
module hazard_weighted_survival_lookup import hwsl_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hwsl_in_if.sink     in_ch,
    hwsl_out_if.source  out_ch
);
    t_cmd cmd;
    t_sts sts;

    hwsl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_action  (in_ch.action),
        .i_in_restart (in_ch.restart),
        .o_in_ready   (in_ch.ready),
        .o_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    hwsl_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_time_point    (in_ch.time_point),
        .i_hazard_ratio  (in_ch.hazard_ratio),
        .i_log_survival  (in_ch.log_survival),
        .o_survival      (out_ch.survival),
        .o_table_empty   (out_ch.table_empty),
        .o_sum_saturated (out_ch.sum_saturated)
    );
endmodule

// ----- rtl/hwsl_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module hwsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

// ----- rtl/hwsl_ctrl.sv -----
// Controller state machine sequencing append, search and exponential.
// Depends on hwsl_pkg.
`timescale 1ns / 1ps
module hwsl_ctrl import hwsl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_action,
    input  logic i_in_restart,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_APP0, S_APP1, S_QRY, S_SINIT, S_SRD, S_SWAIT, S_SUPD,
        S_FRD, S_FWAIT, S_FMUL, S_FADD, S_EINIT, S_ESTEP, S_EDIV, S_EDONE, S_OUT
    } t_state;

    t_state r_state;
    logic   r_restart;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // command decode
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.load_in = i_in_valid;
            S_APP0:  o_cmd.clr_tbl = r_restart;
            S_APP1:  begin
                o_cmd.app_wsum = 1'b1;
                o_cmd.app_wr   = !i_sts.full;
            end
            S_QRY:   o_cmd.res_trivial = 1'b1;
            S_SINIT: o_cmd.srch_init = 1'b1;
            S_SRD:   o_cmd.srch_rd = 1'b1;
            S_SWAIT: o_cmd.srch_rd = 1'b1;
            S_SUPD:  o_cmd.srch_upd = 1'b1;
            S_FRD:   o_cmd.fin_rd = 1'b1;
            S_FWAIT: o_cmd.fin_rd = 1'b1;
            S_FMUL:  o_cmd.fin_mul = 1'b1;
            S_FADD:  o_cmd.fin_add = 1'b1;
            S_EINIT: o_cmd.exp_init = 1'b1;
            S_ESTEP: o_cmd.exp_step = 1'b1;
            S_EDIV:  o_cmd.exp_div = 1'b1;
            S_EDONE: o_cmd.exp_done = 1'b1;
            S_OUT:   ;
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_restart <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_restart <= i_in_restart;
                    r_state   <= (i_in_action == ACT_QUERY) ? S_QRY : S_APP0;
                end
                S_APP0:  r_state <= S_APP1;
                S_APP1:  r_state <= S_IDLE;
                S_QRY:   r_state <= (i_sts.empty || i_sts.t_zero) ? S_OUT : S_SINIT;
                S_SINIT: r_state <= S_SRD;
                S_SRD:   r_state <= i_sts.srch_done ? S_FRD : S_SWAIT;
                S_SWAIT: r_state <= S_SUPD;
                S_SUPD:  r_state <= S_SRD;
                S_FRD:   r_state <= S_FWAIT;
                S_FWAIT: r_state <= S_FMUL;
                S_FMUL:  r_state <= S_FADD;
                S_FADD:  r_state <= S_EINIT;
                S_EINIT: r_state <= S_ESTEP;
                S_ESTEP: r_state <= i_sts.exp_skip ? S_EDONE : S_EDIV;
                S_EDIV:  begin
                    if (i_sts.div_last)
                        r_state <= i_sts.exp_last ? S_EDONE : S_ESTEP;
                end
                S_EDONE: r_state <= S_OUT;
                S_OUT:   if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/hwsl_dp.sv -----
// Datapath: entry table, binary search registers, weighting, exponential.
// Depends on hwsl_pkg and hwsl_ram.
`timescale 1ns / 1ps
module hwsl_dp import hwsl_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic [TIME_W-1:0]        i_time_point,
    input  logic [RATIO_W-1:0]       i_hazard_ratio,
    input  logic signed [LOG_W-1:0]  i_log_survival,
    output logic [SURV_W-1:0]        o_survival,
    output logic                     o_table_empty,
    output logic                     o_sum_saturated
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // captured item
    logic [TIME_W-1:0]       r_t;
    logic [RATIO_W-1:0]      r_ratio;
    logic signed [LOG_W-1:0] r_lg;
    // newest-entry state
    logic [CW-1:0]            r_cnt;
    logic [RATIO_W-1:0]       r_last_ratio;
    logic signed [LOG_W-1:0]  r_last_lg;
    logic signed [SUM_W-1:0]  r_last_sum;
    // search
    logic [AW-1:0] r_lo, r_hi, r_mid;
    // final
    logic signed [SUM_W-1:0] r_prod;
    logic                    r_use_part;
    logic signed [SUM_W-1:0] r_base;
    logic signed [SUM_W-1:0] r_total;
    // exponential
    logic [5:0]   r_k;
    logic [31:0]  r_r32;
    logic [32:0]  r_p;
    logic [3:0]   r_n;
    logic         r_kbig;
    logic         r_pos;
    // divider by the step number: dividend shifts out, quotient shifts in
    logic [31:0]  r_dvd;
    logic [3:0]   r_rem;
    logic [1:0]   r_dcnt;
    // results
    logic [SURV_W-1:0] r_surv;
    logic              r_empty, r_sat;

    // memory
    logic [AW-1:0]      addr;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic [TIME_W-1:0]       rd_t;
    logic [RATIO_W-1:0]      rd_ratio;
    logic signed [LOG_W-1:0] rd_lg;
    logic signed [SUM_W-1:0] rd_sum;

    assign {rd_t, rd_ratio, rd_lg, rd_sum} = rdata;

    // ratio * log-diff, rounded to Q.24 with floor shift
    function automatic logic signed [SUM_W-1:0] f_weigh(
        input logic [RATIO_W-1:0] ratio, input logic signed [LOG_W:0] diff);
        logic signed [58:0] prod;
        begin
            prod = $signed({35'd0, ratio}) * 59'(diff);
            prod = prod + 59'sd32768;
            f_weigh = SUM_W'(prod >>> 16);
        end
    endfunction

    function automatic logic signed [SUM_W-1:0] f_sat(input logic signed [SUM_W:0] v);
        begin
            if (v > $signed({1'b0, SUM_MAX})) f_sat = SUM_MAX;
            else if (v < $signed({1'b1, SUM_MIN})) f_sat = SUM_MIN;
            else f_sat = v[SUM_W-1:0];
        end
    endfunction

    logic signed [LOG_W:0]   app_diff;
    logic signed [SUM_W-1:0] app_w;
    logic signed [SUM_W-1:0] app_sum;
    logic [AW-1:0]           mid_n;
    logic [AW:0]             mid_sum;

    assign app_diff = {r_lg[LOG_W-1], r_lg} - {r_last_lg[LOG_W-1], r_last_lg};
    assign app_w    = f_weigh(r_last_ratio, app_diff);
    assign app_sum  = (r_cnt == '0) ? '0 :
        f_sat({r_last_sum[SUM_W-1], r_last_sum} + {app_w[SUM_W-1], app_w});
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi} + {{AW{1'b0}}, 1'b1};
    assign mid_n   = mid_sum[AW:1];

    always_comb begin
        if (i_cmd.app_wr) addr = r_cnt[AW-1:0];
        else if (i_cmd.fin_rd) addr = r_lo;
        else addr = r_mid;
    end
    assign wdata = {r_t, r_ratio, r_lg, app_sum};

    hwsl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.app_wr),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    assign o_sts.full      = (r_cnt >= CW'(TABLE_DEPTH));
    assign o_sts.empty     = (r_cnt == '0);
    assign o_sts.srch_done = (r_lo >= r_hi);
    assign o_sts.t_zero    = (r_t == '0);
    assign o_sts.exp_last  = (r_n == 4'd1);
    assign o_sts.exp_skip  = r_kbig || r_pos;
    assign o_sts.div_last  = (r_dcnt == 2'd3);

    // exponential helpers
    logic [SUM_W-1:0] y_abs;
    logic [63:0]      pr;
    logic [31:0]      t_q;
    logic [72:0]      p_sh;
    assign y_abs = SUM_W'(-r_total);
    assign pr    = r_p[31:0] * r_r32;
    // p == 2^32 makes product r32 << 32; handled via top bit
    assign t_q   = r_p[32] ? r_r32 : pr[63:32];
    assign p_sh  = ({40'd0, r_p} + (73'd1 << (15 + r_k))) >> (16 + r_k);

    // k = y / LN2 by one-bit-per-cycle long division would cost cycles; y < 2^47
    // so k < 2^24 range; restoring division runs over exp_init only via compare chain
    logic [5:0]  k_val;
    logic [SUM_W-1:0] rem_val;
    logic        kbig_val;
    always_comb begin
        k_val = '0;
        rem_val = y_abs;
        kbig_val = (y_abs >= SUM_W'(64'd41 * 64'd11629080 + 64'd11629080));
        // at most 41 subtractions collapsed as a 6-bit restoring divide
        for (int b = 5; b >= 0; b--) begin
            if (rem_val >= (SUM_W'(LN2_Q24) << b)) begin
                rem_val = rem_val - (SUM_W'(LN2_Q24) << b);
                k_val[b] = 1'b1;
            end
        end
    end

    // eight restoring quotient bits per cycle; remainder stays below n <= 10
    logic [31:0] d_dvd;
    logic [3:0]  d_rem;
    logic [4:0]  d_tmp;
    always_comb begin
        d_dvd = r_dvd;
        d_rem = r_rem;
        d_tmp = '0;
        for (int b = 0; b < 8; b++) begin
            d_tmp = {d_rem, d_dvd[31]};
            d_dvd = {d_dvd[30:0], 1'b0};
            if (d_tmp >= {1'b0, r_n}) begin
                d_tmp    = d_tmp - {1'b0, r_n};
                d_dvd[0] = 1'b1;
            end
            d_rem = d_tmp[3:0];
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_last_ratio <= '0;
            r_last_lg    <= '0;
            r_last_sum   <= '0;
        end else begin
            if (i_cmd.clr_tbl) begin
                r_cnt        <= '0;
                r_last_ratio <= '0;
                r_last_lg    <= '0;
                r_last_sum   <= '0;
            end
            if (i_cmd.app_wr) begin
                r_cnt        <= r_cnt + 1'b1;
                r_last_ratio <= r_ratio;
                r_last_lg    <= r_lg;
                r_last_sum   <= app_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // capture item
        if (i_cmd.load_in) begin
            r_t     <= i_time_point;
            r_ratio <= i_hazard_ratio;
            r_lg    <= i_log_survival;
        end
        // trivial result
        if (i_cmd.res_trivial) begin
            r_surv  <= SURV_ONE;
            r_empty <= (r_cnt == '0);
            r_sat   <= 1'b0;
        end
        // search
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= AW'(r_cnt - 1'b1);
        end
        if (i_cmd.srch_rd && !(r_lo >= r_hi)) r_mid <= mid_n;
        if (i_cmd.srch_upd) begin
            if (rd_t <= r_t) r_lo <= r_mid;
            else r_hi <= r_mid - 1'b1;
        end
        // partial term
        if (i_cmd.fin_mul) begin
            r_base     <= rd_sum;
            r_use_part <= (r_t > rd_t) && ({1'b0, r_lo} + 1'b1 < (AW+1)'(r_cnt));
            r_prod     <= f_weigh(rd_ratio,
                          {r_lg[LOG_W-1], r_lg} - {rd_lg[LOG_W-1], rd_lg});
        end
        if (i_cmd.fin_add) begin
            r_total <= r_use_part ?
                f_sat({r_base[SUM_W-1], r_base} + {r_prod[SUM_W-1], r_prod}) :
                r_base;
        end
        // exponential
        if (i_cmd.exp_init) begin
            r_pos  <= !r_total[SUM_W-1];
            r_kbig <= kbig_val;
            r_k    <= k_val;
            r_r32  <= {rem_val[23:0], 8'd0};
            r_p    <= 33'h1_0000_0000;
            r_n    <= 4'd10;
        end
        // step: load the divider with the scaled product
        if (i_cmd.exp_step) begin
            r_dvd  <= t_q;
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        // divide chunk; the last one closes the step
        if (i_cmd.exp_div) begin
            r_dvd  <= d_dvd;
            r_rem  <= d_rem;
            r_dcnt <= r_dcnt + 1'b1;
            if (r_dcnt == 2'd3) begin
                r_p <= 33'h1_0000_0000 - {1'b0, d_dvd};
                r_n <= r_n - 1'b1;
            end
        end
        if (i_cmd.exp_done) begin
            r_empty <= 1'b0;
            r_sat   <= (r_total == SUM_MIN);
            if (r_pos) r_surv <= SURV_ONE;
            else if (r_kbig) r_surv <= '0;
            else r_surv <= p_sh[SURV_W-1:0];
        end
    end

    assign o_survival      = r_surv;
    assign o_table_empty   = r_empty;
    assign o_sum_saturated = r_sat;
endmodule

// ----- tb/sv/hwsl_tb_if.sv -----
// Testbench package: item types for the input and result channels.
// Depends on hwsl_pkg.
`timescale 1ns / 1ps
package hwsl_tb_pkg;
    import hwsl_pkg::*;

    // one input item as the sender drives it
    typedef struct packed {
        logic                    action;
        logic                    restart;
        logic [TIME_W-1:0]       time_point;
        logic [RATIO_W-1:0]      hazard_ratio;
        logic signed [LOG_W-1:0] log_survival;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [SURV_W-1:0] survival;
        logic              table_empty;
        logic              sum_saturated;
    } t_surv_res;
endpackage

// ----- tb/sv/hazard_weighted_survival_lookup_tb.sv -----
// Testbench for hazard_weighted_survival_lookup: directed and random appends
// and queries, each query's result predicted in-bench and checked in order.
// Depends on hwsl_pkg, hwsl_if, hwsl_tb_pkg and the block's RTL.
`timescale 1ns / 1ps
module hazard_weighted_survival_lookup_tb;
    import hwsl_pkg::*;
    import hwsl_tb_pkg::*;

    localparam int DEPTH     = TABLE_DEPTH_DEF;
    localparam int STALL_MAX = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hwsl_in_if  in_ch ();
    hwsl_out_if out_ch ();

    hazard_weighted_survival_lookup dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state: the stored table and the newest entry
    logic [TIME_W-1:0]          tbl_time [DEPTH];
    logic [RATIO_W-1:0]         tbl_ratio [DEPTH];
    logic signed [LOG_W-1:0]    tbl_log [DEPTH];
    logic signed [SUM_W-1:0]    tbl_sum [DEPTH];
    int                         n_entries = 0;
    logic [RATIO_W-1:0]         newest_ratio = '0;
    logic signed [LOG_W-1:0]    newest_log = '0;
    logic signed [SUM_W-1:0]    newest_sum = '0;

    t_surv_res expected_surv [$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  n_errors = 0;
    int  n_queries = 0;
    int  n_appends = 0;
    int  n_results = 0;
    int  idle_cycles = 0;

    function automatic logic signed [SUM_W-1:0] clamp_sum(longint v);
        if (v > longint'(SUM_MAX)) return SUM_MAX;
        if (v < longint'(SUM_MIN)) return SUM_MIN;
        return v[SUM_W-1:0];
    endfunction

    // ratio * log difference in Q.40, rounded to Q.24 with a floor shift
    function automatic longint weighted_step(logic [RATIO_W-1:0] ratio, longint diff);
        longint prod;
        prod = longint'({1'b0, ratio}) * diff + 64'sd32768;
        return prod >>> 16;
    endfunction

    function automatic logic [SURV_W-1:0] surv_from_sum(logic signed [SUM_W-1:0] s);
        longint  y, k, r;
        logic [63:0] p, r32, t;
        if (s >= 0) return SURV_ONE;
        y = -longint'(s);
        k = y / longint'(LN2_Q24);
        r = y - k * longint'(LN2_Q24);
        if (k > 40) return '0;
        r32 = 64'(r) << 8;
        p = 64'd1 << 32;
        for (int n = 10; n >= 1; n--) begin
            t = (p * r32) >> 32;
            p = (64'd1 << 32) - t / 64'(n);
        end
        return SURV_W'((p + (64'd1 << (15 + k))) >> (16 + k));
    endfunction

    // apply one accepted item to the predictor
    task automatic predict_item(t_in_item it);
        logic signed [SUM_W-1:0] s;
        t_surv_res res;
        int lo, hi, mid;
        longint total;
        if (it.action == ACT_APPEND) begin
            n_appends++;
            if (it.restart) begin
                n_entries = 0;
                newest_ratio = '0;
                newest_log = '0;
                newest_sum = '0;
            end
            if (n_entries >= DEPTH) return;
            if (n_entries == 0) s = '0;
            else s = clamp_sum(longint'(newest_sum) + weighted_step(newest_ratio,
                     longint'(it.log_survival) - longint'(newest_log)));
            tbl_time[n_entries] = it.time_point;
            tbl_ratio[n_entries] = it.hazard_ratio;
            tbl_log[n_entries] = it.log_survival;
            tbl_sum[n_entries] = s;
            n_entries++;
            newest_ratio = it.hazard_ratio;
            newest_log = it.log_survival;
            newest_sum = s;
            return;
        end
        n_queries++;
        res.survival = SURV_ONE;
        res.table_empty = (n_entries == 0);
        res.sum_saturated = 1'b0;
        if (n_entries != 0 && it.time_point != 0) begin
            lo = 0;
            hi = n_entries - 1;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (tbl_time[mid] <= it.time_point) lo = mid;
                else hi = mid - 1;
            end
            total = tbl_sum[lo];
            if (it.time_point > tbl_time[lo] && lo + 1 < n_entries)
                total = clamp_sum(total + weighted_step(tbl_ratio[lo],
                        longint'(it.log_survival) - longint'(tbl_log[lo])));
            res.survival = surv_from_sum(total[SUM_W-1:0]);
            res.sum_saturated = (total == longint'(SUM_MIN));
        end
        expected_surv.push_back(res);
    endtask

    // drive one item and hold it until accepted; valid drops only while idling
    task automatic send_item(t_in_item it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        {in_ch.action, in_ch.restart, in_ch.time_point, in_ch.hazard_ratio,
         in_ch.log_survival} <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_item(it);
        @(negedge i_clk);
    endtask

    task automatic append_entry(logic rs, logic [31:0] tp, logic [23:0] hr, logic [31:0] lg);
        send_item('{ACT_APPEND, rs, tp, hr, lg});
    endtask

    task automatic query_at(logic [31:0] tp, logic [31:0] lg, logic rs = 1'b0,
                            logic [23:0] hr = '0);
        send_item('{ACT_QUERY, rs, tp, hr, lg});
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_surv.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // receiver: random stalls, compare against the oldest expectation
    always @(negedge i_clk)
        out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

    always @(posedge i_clk) begin
        t_surv_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (expected_surv.size() == 0) begin
                $error("result with no query waiting: survival %0d", out_ch.survival);
                n_errors++;
            end else begin
                want = expected_surv.pop_front();
                if (out_ch.survival !== want.survival) begin
                    $error("survival: expected %0d, got %0d", want.survival, out_ch.survival);
                    n_errors++;
                end
                if (out_ch.table_empty !== want.table_empty) begin
                    $error("table_empty: expected %0d, got %0d", want.table_empty,
                           out_ch.table_empty);
                    n_errors++;
                end
                if (out_ch.sum_saturated !== want.sum_saturated) begin
                    $error("sum_saturated: expected %0d, got %0d", want.sum_saturated,
                           out_ch.sum_saturated);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving either way
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // empty table, zero time, restart and ratio on a query
    task automatic test_trivial_queries();
        query_at(32'h0001_0000, 32'sh8000_0000);
        query_at(32'h0, 32'h0, 1'b1, 24'hFF_FFFF);
        append_entry(1'b1, 32'h0001_0000, 24'h01_0000, 32'h0);
        query_at(32'h0, 32'sh8000_0000);
        query_at(32'h0000_0001, 32'sh8000_0000, 1'b1, 24'hFF_FFFF);
    endtask

    // extremes: very negative sum, before first, past last, exact hit, partial
    task automatic test_extremes();
        append_entry(1'b1, 32'h0000_1000, 24'hFF_FFFF, 32'h0);
        append_entry(1'b0, 32'h0010_0000, 24'hFF_FFFF, 32'sh8000_0000);
        append_entry(1'b0, 32'hFFFF_FFFF, 24'h00_0000, 32'h0);
        query_at(32'h0000_0FFF, 32'h0);
        query_at(32'h0000_1000, 32'h0);
        query_at(32'h0000_8000, 32'shC000_0000);
        query_at(32'h0010_0000, 32'h0);
        query_at(32'hFFFF_FFFF, 32'sh8000_0000);
        append_entry(1'b1, 32'h0001_0000, 24'h01_0000, 32'h0);
        append_entry(1'b0, 32'h0002_0000, 24'h00_8000, 32'shFF80_0000);
        append_entry(1'b0, 32'h0001_8000, 24'h01_0000, 32'shFF00_0000);
        query_at(32'h0001_8000, 32'shFFC0_0000);
        query_at(32'h0002_8000, 32'shFE00_0000);
        query_at(32'h7FFF_FFFF, 32'h0000_0000);
    endtask

    // fill the whole table, then one more append that must be dropped
    task automatic test_full_table();
        for (int i = 0; i < DEPTH + 1; i++)
            append_entry(i == 0, 32'(i) << 12, 24'($urandom_range(32'h2_0000)),
                         -32'(i) * 32'sd2000);
        query_at(32'hFFFF_FFFF, 32'sh8000_0000);
        query_at(32'(DEPTH / 2) << 12 | 32'h800, 32'shFFF0_0000);
    endtask

    // random tables in time order with random content, plus noise
    task automatic test_random(int n_items);
        int sent, tbl_len;
        logic [31:0] tp, lg;
        sent = 0;
        while (sent < n_items) begin
            tbl_len = $urandom_range(15);
            tp = $urandom_range(4096);
            lg = -$urandom_range(1 << 20);
            for (int i = 0; i < tbl_len && sent < n_items; i++) begin
                if ($urandom_range(9) == 0)
                    append_entry($urandom_range(1), $urandom, $urandom, $urandom);
                else
                    append_entry(i == 0, tp, $urandom, lg);
                tp += $urandom_range(1 << 20);
                lg -= $urandom_range(1 << 24);
                sent++;
            end
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(3))
                    0: query_at($urandom, $urandom, $urandom, $urandom);
                    1: query_at($urandom_range(tp), lg - $urandom_range(1 << 24));
                    2: query_at(0, -$urandom_range(1 << 30));
                    default: query_at($urandom_range(tp), 32'sh8000_0000 | $urandom);
                endcase
                sent++;
            end
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = ACT_APPEND;
        in_ch.restart = 1'b0;
        in_ch.time_point = '0;
        in_ch.hazard_ratio = '0;
        in_ch.log_survival = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_trivial_queries();
        test_extremes();
        test_full_table();
        wait_drained();
        test_random(175);
        send_idle_pct = 61;
        test_random(175);
        send_idle_pct = 0;
        recv_stall_pct = 61;
        test_random(175);
        send_idle_pct = 26;
        recv_stall_pct = 26;
        test_random(175);
        wait_drained();

        $display("Covered %0d appends and %0d queries, %0d results checked.",
                 n_appends, n_queries, n_results);
        $display("Idling phases: none, sender, receiver, both.");
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
